### rtl/nfbta_pkg.sv
// Types and constants shared by the next-fit boundary-tag allocator.
package nfbta_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] req_bytes;
        logic [15:0] block_addr;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [1:0]  status;
    } out_item_t;

    // Heap word port request: byte addresses, one read and one write per cycle.
    typedef struct packed {
        logic        rd_en;
        logic [31:0] rd_addr;
        logic        wr_en;
        logic [31:0] wr_addr;
        logic [31:0] wr_data;
    } mem_req_t;

    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic [31:0] SIZE_MASK   = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT   = 32'h0000_0001;
    localparam logic [31:0] MIN_BLOCK   = 32'd16;
    localparam logic [31:0] FIRST_BLOCK = 32'd8;

    typedef enum logic [4:0] {
        S_IDLE,
        S_I0, S_I1, S_I2, S_I3,
        S_WREQ, S_WCHK, S_FREQ, S_FCHK,
        S_G0, S_G1, S_G2,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_F0, S_F1, S_F2,
        S_P0, S_P1, S_P2, S_P3, S_P4,
        S_DONE
    } nfbta_state_t;

endpackage

### rtl/nfbta_heap_ram.sv
// Heap word memory: one write and one registered read per cycle, zero outside the heap.
module nfbta_heap_ram #(
    parameter int DEPTH = 16384
) (
    input  logic              aclk,
    input  nfbta_pkg::mem_req_t req,
    output logic [31:0]       rd_data
);
    import nfbta_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_word_reg;
    logic        rd_oob_reg;
    logic        wr_in;
    logic        rd_in;

    assign wr_in = req.wr_addr[31:2] < 30'(DEPTH);
    assign rd_in = req.rd_addr[31:2] < 30'(DEPTH);

    always_ff @(posedge aclk) begin
        if (req.wr_en && wr_in) begin
            mem[req.wr_addr[IW+1:2]] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_word_reg <= mem[req.rd_addr[IW+1:2]];
            rd_oob_reg  <= !rd_in;
        end
    end

    assign rd_data = rd_oob_reg ? 32'd0 : rd_word_reg;

endmodule

### rtl/next_fit_boundary_tag_allocator.sv
// Next-fit allocator over boundary-tagged heap words, run by a word-at-a-time sequencer.
// Init writes the prologue and epilogue and grows the heap; free clears the tag and merges
// neighbours; allocate walks from the rover, wraps once, then grows (unless out of memory)
// and places the block, splitting when the rest is large enough; bad requests go to the result.
// One request at a time; the next is accepted from the cycle the result turns valid.
// Reset clears the sequencer, result valid, rover and heap break; heap words stay unwritten.
module next_fit_boundary_tag_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  nfbta_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output nfbta_pkg::out_item_t m_data
);
    import nfbta_pkg::*;

    localparam int          HW       = $clog2(HEAP_BYTES + 1);
    localparam logic [31:0] HEAP32   = 32'(HEAP_BYTES);
    localparam logic [31:0] CHUNK32  = 32'(CHUNK_BYTES);
    localparam logic [31:0] CHUNK_SZ =
        32'(((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4);

    nfbta_state_t state_reg, state_next;
    logic [1:0]   kind_reg, kind_next;
    logic         phase_reg, phase_next;
    logic         pa_reg, pa_next;
    logic         na_reg, na_next;
    logic         split_reg, split_next;
    logic [31:0]  asize_reg, asize_next;
    logic [31:0]  bp_reg, bp_next;
    logic [31:0]  start_reg, start_next;
    logic [31:0]  size_reg, size_next;
    logic [31:0]  nxt_reg, nxt_next;
    logic [31:0]  prv_reg, prv_next;
    logic [31:0]  nsz_reg, nsz_next;
    logic [31:0]  w2_addr_reg, w2_addr_next;
    logic [31:0]  w2_data_reg, w2_data_next;
    logic [31:0]  rov_reg, rov_next;
    logic [HW-1:0] heap_end_reg, heap_end_next;
    logic [15:0]  res_reg, res_next;
    logic [1:0]   st_reg, st_next;
    logic         m_valid_reg, m_valid_next;
    out_item_t    out_reg, out_next;

    mem_req_t     mreq;
    logic [31:0]  rd_data;
    logic [31:0]  rd_size;
    logic         rd_alloc;
    logic [31:0]  he32;
    logic         accept;
    logic         walk_ok;
    logic [31:0]  walk_s;
    logic         fits;
    logic         free_ok;
    logic [31:0]  asize_calc;
    logic [31:0]  grow_sz;
    logic         grow_fail;
    logic         out_free;
    logic         merge_pa_na;

    nfbta_heap_ram #(
        .DEPTH(HEAP_BYTES / 4)
    ) u_ram (
        .aclk   (aclk),
        .req    (mreq),
        .rd_data(rd_data)
    );

    assign he32     = 32'(heap_end_reg);
    assign rd_size  = rd_data & SIZE_MASK;
    assign rd_alloc = rd_data[0];
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign walk_ok    = (bp_reg >= 32'd4) && (bp_reg <= he32);
    assign walk_s     = (rd_size > he32 - bp_reg) ? 32'd0 : rd_size;
    assign fits       = (walk_s >= asize_reg) && !rd_alloc;
    assign free_ok    = (heap_end_reg != '0) && ({s_data.block_addr[15:2], 2'b00} >= 16'd16)
                        && (32'({s_data.block_addr[15:2], 2'b00}) < he32);
    assign asize_calc = (s_data.req_bytes <= 16'd8) ? 32'd16
                        : ((32'(s_data.req_bytes) + 32'd15) & SIZE_MASK);
    assign grow_sz    = (asize_reg > CHUNK32) ? asize_reg : CHUNK_SZ;
    assign grow_fail  = size_reg > HEAP32 - he32;
    assign merge_pa_na = pa_reg && na_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_data.kind)
                        KIND_INIT:  state_next = S_I0;
                        KIND_ALLOC: state_next = (s_data.req_bytes == 16'd0 || heap_end_reg == '0)
                                                 ? S_DONE : S_WREQ;
                        KIND_FREE:  state_next = free_ok ? S_F0 : S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_I0: state_next = S_I1;
            S_I1: state_next = S_I2;
            S_I2: state_next = S_I3;
            S_I3: state_next = S_G0;
            S_WREQ: begin
                if (walk_ok)        state_next = S_WCHK;
                else if (!phase_reg) state_next = S_FREQ;
                else                state_next = S_G0;
            end
            S_WCHK: begin
                if (!phase_reg) begin
                    if (walk_s == 32'd0) state_next = S_FREQ;
                    else if (fits)       state_next = S_P0;
                    else                 state_next = S_WREQ;
                end else begin
                    if (walk_s == 32'd0 || bp_reg == start_reg) state_next = S_G0;
                    else if (fits)                               state_next = S_P0;
                    else                                         state_next = S_WREQ;
                end
            end
            S_FREQ: state_next = S_FCHK;
            S_FCHK: state_next = S_WREQ;
            S_G0:   state_next = grow_fail ? S_DONE : S_G1;
            S_G1:   state_next = S_G2;
            S_G2:   state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4: begin
                if (!merge_pa_na)                 state_next = S_M5;
                else if (kind_reg == KIND_ALLOC)  state_next = S_P0;
                else                              state_next = S_DONE;
            end
            S_M5:   state_next = (kind_reg == KIND_ALLOC) ? S_P0 : S_DONE;
            S_F0:   state_next = S_F1;
            S_F1:   state_next = S_F2;
            S_F2:   state_next = S_M0;
            S_P0:   state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = split_reg ? S_P3 : S_DONE;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_DONE;
            S_DONE: state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory port and result.
    always_comb begin
        logic [31:0] tot;
        kind_next     = kind_reg;
        phase_next    = phase_reg;
        pa_next       = pa_reg;
        na_next       = na_reg;
        split_next    = split_reg;
        asize_next    = asize_reg;
        bp_next       = bp_reg;
        start_next    = start_reg;
        size_next     = size_reg;
        nxt_next      = nxt_reg;
        prv_next      = prv_reg;
        nsz_next      = nsz_reg;
        w2_addr_next  = w2_addr_reg;
        w2_data_next  = w2_data_reg;
        rov_next      = rov_reg;
        heap_end_next = heap_end_reg;
        res_next      = res_reg;
        st_next       = st_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mreq          = '0;
        tot           = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next  = s_data.kind;
                    res_next   = 16'd0;
                    st_next    = ST_OK;
                    asize_next = asize_calc;
                    phase_next = 1'b0;
                    bp_next    = rov_reg;
                    start_next = rov_reg;
                    if (s_data.kind == KIND_FREE) begin
                        bp_next = 32'({s_data.block_addr[15:2], 2'b00});
                    end
                    if (s_data.kind == KIND_ALLOC) begin
                        if (s_data.req_bytes == 16'd0) st_next = ST_ZERO;
                        else if (heap_end_reg == '0)   st_next = ST_OOM;
                    end
                end
            end
            S_I0: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 32'd0;
                mreq.wr_data = 32'd0;
            end
            S_I1: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 32'd4;
                mreq.wr_data = 32'd8 | ALLOC_BIT;
            end
            S_I2: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = 32'd8;
                mreq.wr_data = 32'd8 | ALLOC_BIT;
            end
            S_I3: begin
                mreq.wr_en    = 1'b1;
                mreq.wr_addr  = 32'd12;
                mreq.wr_data  = ALLOC_BIT;
                heap_end_next = HW'(16);
                rov_next      = 32'd16;
                size_next     = CHUNK_SZ;
            end
            S_WREQ: begin
                if (walk_ok) begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = bp_reg - 32'd4;
                end else if (phase_reg) begin
                    size_next = grow_sz;
                end
            end
            S_WCHK: begin
                if (!phase_reg ? (walk_s == 32'd0)
                               : (walk_s == 32'd0 || bp_reg == start_reg)) begin
                    if (phase_reg) size_next = grow_sz;
                end else if (fits) begin
                    rov_next = bp_reg;
                end else begin
                    bp_next = bp_reg + walk_s;
                end
            end
            S_FREQ: begin
                // Restart from the prologue block; the walk skips past it.
                bp_next      = FIRST_BLOCK;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = FIRST_BLOCK - 32'd4;
            end
            S_FCHK: begin
                bp_next    = bp_reg + walk_s;
                phase_next = 1'b1;
            end
            S_G0: begin
                if (grow_fail) begin
                    st_next = ST_OOM;
                end else begin
                    bp_next      = he32;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = he32 - 32'd4;
                    mreq.wr_data = size_reg;
                end
            end
            S_G1: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg + size_reg - 32'd8;
                mreq.wr_data = size_reg;
            end
            S_G2: begin
                mreq.wr_en    = 1'b1;
                mreq.wr_addr  = bp_reg + size_reg - 32'd4;
                mreq.wr_data  = ALLOC_BIT;
                heap_end_next = heap_end_reg + size_reg[HW-1:0];
            end
            S_M0: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = bp_reg - 32'd4;
            end
            S_M1: begin
                size_next    = rd_size;
                nxt_next     = bp_reg + rd_size;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = bp_reg - 32'd8;
            end
            S_M2: begin
                pa_next      = rd_alloc;
                prv_next     = bp_reg - rd_size;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = nxt_reg - 32'd4;
            end
            S_M3: begin
                nsz_next     = rd_size;
                na_next      = rd_alloc;
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = prv_reg - 32'd4;
            end
            S_M4: begin
                // rd_size holds the previous block's size here.
                if (merge_pa_na) begin
                    // nothing to join
                end else if (pa_reg) begin
                    tot          = size_reg + nsz_reg;
                    if (rov_reg == nxt_reg) rov_next = bp_reg;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = bp_reg - 32'd4;
                    mreq.wr_data = tot;
                    w2_addr_next = bp_reg + tot - 32'd8;
                    w2_data_next = tot;
                end else if (na_reg) begin
                    tot          = size_reg + rd_size;
                    if (rov_reg == bp_reg) rov_next = prv_reg;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = bp_reg + size_reg - 32'd8;
                    mreq.wr_data = tot;
                    w2_addr_next = prv_reg - 32'd4;
                    w2_data_next = tot;
                    bp_next      = prv_reg;
                end else begin
                    tot          = size_reg + rd_size + nsz_reg;
                    if (rov_reg == bp_reg || rov_reg == nxt_reg) rov_next = prv_reg;
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = prv_reg - 32'd4;
                    mreq.wr_data = tot;
                    w2_addr_next = nxt_reg + nsz_reg - 32'd8;
                    w2_data_next = tot;
                    bp_next      = prv_reg;
                end
            end
            S_M5: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = w2_addr_reg;
                mreq.wr_data = w2_data_reg;
            end
            S_F0: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = bp_reg - 32'd4;
            end
            S_F1: begin
                size_next    = rd_size;
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg - 32'd4;
                mreq.wr_data = rd_size;
            end
            S_F2: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg + size_reg - 32'd8;
                mreq.wr_data = size_reg;
            end
            S_P0: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = bp_reg - 32'd4;
            end
            S_P1: begin
                size_next    = rd_size;
                split_next   = rd_size >= asize_reg + MIN_BLOCK;
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg - 32'd4;
                mreq.wr_data = ((rd_size >= asize_reg + MIN_BLOCK) ? asize_reg : rd_size)
                               | ALLOC_BIT;
            end
            S_P2: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg + (split_reg ? asize_reg : size_reg) - 32'd8;
                mreq.wr_data = (split_reg ? asize_reg : size_reg) | ALLOC_BIT;
                res_next     = bp_reg[15:0];
            end
            S_P3: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg + asize_reg - 32'd4;
                mreq.wr_data = size_reg - asize_reg;
            end
            S_P4: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = bp_reg + size_reg - 32'd8;
                mreq.wr_data = size_reg - asize_reg;
            end
            S_DONE: begin
                if (out_free) begin
                    out_next.result_addr = res_reg;
                    out_next.status      = st_reg;
                    m_valid_next         = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            rov_reg      <= '0;
            heap_end_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rov_reg      <= rov_next;
            heap_end_reg <= heap_end_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        phase_reg   <= phase_next;
        pa_reg      <= pa_next;
        na_reg      <= na_next;
        split_reg   <= split_next;
        asize_reg   <= asize_next;
        bp_reg      <= bp_next;
        start_reg   <= start_next;
        size_reg    <= size_next;
        nxt_reg     <= nxt_next;
        prv_reg     <= prv_next;
        nsz_reg     <= nsz_next;
        w2_addr_reg <= w2_addr_next;
        w2_data_reg <= w2_data_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_break_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(heap_end_reg) <= HEAP32)
        else $error("heap break beyond heap");

    a_break_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_end_reg[2:0] == 3'd0)
        else $error("heap break not double-word aligned");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != S_IDLE)
        else $error("accepted request did not start");
`endif

endmodule
